>>> rtl/script_token_scanner_top_macros.svh
// Assertion macros shared by the script token scanner RTL.
`ifndef SCRIPT_TOKEN_SCANNER_TOP_MACROS_SVH
`define SCRIPT_TOKEN_SCANNER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/sts_pkg.sv
// Shared types and constants of the script token scanner.
`timescale 1ns / 1ps
`default_nettype none

package sts_pkg;

   localparam int STS_POSITION_BITS = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int GROUP_SIZE = 3;

   typedef enum logic [1:0] {
      KIND_IDENT,
      KIND_STRING,
      KIND_NUMBER,
      KIND_OTHER
   } kind_type;

   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_STR_D,
      MODE_STR_S,
      MODE_ZERO,
      MODE_HEX,
      MODE_INT,
      MODE_DOT,
      MODE_FRAC,
      MODE_EXP_START,
      MODE_EXP,
      MODE_SUFFIX,
      MODE_SLASH,
      MODE_LINE,
      MODE_BLOCK,
      MODE_BLOCK_STAR
   } mode_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] start;
      logic [15:0] length;
      logic        follows;
   } token_type;

   typedef struct packed {
      logic [1:0]                  count;
      token_type [GROUP_SIZE-1:0]  tok;
   } group_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

>>> rtl/sts_front.sv
// Front end: accepts text bytes, runs the lexer state and builds token groups.
`timescale 1ns / 1ps
`default_nettype none

module sts_front import sts_pkg::*; #(
   parameter int POSITION_BITS = STS_POSITION_BITS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [7:0]       req_char_code,
   input  wire logic             req_end_of_text,
   input  wire queue_status_type q_status,
   output logic                  push_valid,
   output group_type             push_group
);

   localparam int PB = POSITION_BITS;

   typedef struct packed {
      kind_type        kind;
      logic [PB-1:0]   start;
      logic [PB-1:0]   length;
      logic            req;
      logic            trans;
   } emit_type;

   function automatic logic is_digit(logic [7:0] b);
      return b inside {["0":"9"]};
   endfunction

   function automatic logic is_alpha(logic [7:0] b);
      return b inside {["a":"z"], ["A":"Z"], "_"};
   endfunction

   function automatic logic is_hex(logic [7:0] b);
      return b inside {["0":"9"], ["a":"f"], ["A":"F"]};
   endfunction

   function automatic logic is_suffix(logic [7:0] b);
      return b inside {"u", "i", "p", "l"};
   endfunction

   function automatic logic [7:0] req_char(logic [2:0] i);
      logic [7:0] c;
      case (i)
         3'd0: c = "r";
         3'd1: c = "e";
         3'd2: c = "q";
         3'd3: c = "u";
         3'd4: c = "i";
         3'd5: c = "r";
         3'd6: c = "e";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [PB-1:0] sat_inc(logic [PB-1:0] p);
      return (&p) ? p : p + PB'(1);
   endfunction

   function automatic logic [15:0] clamp16(logic [PB-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return (w > 32'd65535) ? 16'hFFFF : w[15:0];
   endfunction

   function automatic emit_type mk_emit(kind_type k, logic [PB-1:0] s, logic [PB-1:0] l,
                                        logic r, logic t);
      emit_type e;
      e.kind = k;
      e.start = s;
      e.length = l;
      e.req = r;
      e.trans = t;
      return e;
   endfunction

   mode_type      mode_ff, mode_in;
   logic [PB-1:0] pos_ff, pos_in;
   logic [PB-1:0] begin_ff, begin_in;
   logic [PB-1:0] dot_ff, dot_in;
   logic [7:0]    prev_ff, prev_in;
   logic [7:0]    prev2_ff, prev2_in;
   logic [2:0]    prog_ff, prog_in;
   logic          cand_ff, cand_in;
   logic          ar_ff, ar_in;

   logic          accept;
   emit_type      em [GROUP_SIZE];
   logic [1:0]    n_emit;
   logic          do_start;
   logic          req_hit;
   logic          escaped;
   logic [7:0]    quote;
   logic [7:0]    b;

   assign req_ready = !q_status.full;
   assign accept = req_valid && req_ready;
   assign b = req_char_code;

   always_comb begin
      mode_in = mode_ff;
      pos_in = pos_ff;
      begin_in = begin_ff;
      dot_in = dot_ff;
      prev_in = prev_ff;
      prev2_in = prev2_ff;
      prog_in = prog_ff;
      cand_in = cand_ff;
      for (int i = 0; i < GROUP_SIZE; i++) begin
         em[i] = '0;
      end
      n_emit = 2'd0;
      do_start = 1'b0;
      req_hit = cand_ff && (prog_ff == 3'd7);
      escaped = (prev_ff == "\\") && (prev2_ff != "\\");
      quote = (mode_ff == MODE_STR_D) ? 8'("\"") : 8'("'");

      if (req_end_of_text) begin
         case (mode_ff)
            MODE_IDENT: begin
               em[n_emit] = mk_emit(KIND_IDENT, begin_ff, pos_ff - begin_ff, req_hit, 1'b0);
               n_emit = n_emit + 2'd1;
            end
            MODE_ZERO, MODE_HEX, MODE_INT, MODE_FRAC, MODE_EXP_START, MODE_EXP,
            MODE_SUFFIX: begin
               em[n_emit] = mk_emit(KIND_NUMBER, begin_ff, pos_ff - begin_ff, 1'b0, 1'b0);
               n_emit = n_emit + 2'd1;
            end
            MODE_DOT: begin
               em[n_emit] = mk_emit(KIND_NUMBER, begin_ff, dot_ff - begin_ff, 1'b0, 1'b0);
               n_emit = n_emit + 2'd1;
               em[n_emit] = mk_emit(KIND_OTHER, dot_ff, PB'(1), 1'b0, 1'b0);
               n_emit = n_emit + 2'd1;
            end
            MODE_SLASH: begin
               em[n_emit] = mk_emit(KIND_OTHER, begin_ff, PB'(1), 1'b0, 1'b0);
               n_emit = n_emit + 2'd1;
            end
            default: begin
            end
         endcase
         mode_in = MODE_IDLE;
         pos_in = '0;
         begin_in = '0;
         dot_in = '0;
         prev_in = '0;
         prev2_in = '0;
         prog_in = '0;
         cand_in = 1'b1;
      end else begin
         case (mode_ff)
            MODE_IDENT: begin
               if (is_alpha(b) || is_digit(b)) begin
                  if (prog_ff < 3'd7 && cand_ff && b == req_char(prog_ff)) begin
                     prog_in = prog_ff + 3'd1;
                  end else begin
                     cand_in = 1'b0;
                  end
               end else begin
                  em[n_emit] = mk_emit(KIND_IDENT, begin_ff, pos_ff - begin_ff, req_hit, 1'b0);
                  n_emit = n_emit + 2'd1;
                  do_start = 1'b1;
               end
            end
            MODE_STR_D, MODE_STR_S: begin
               if (b == quote && !escaped) begin
                  em[n_emit] = mk_emit(KIND_STRING, begin_ff, pos_ff - begin_ff, 1'b0, 1'b0);
                  n_emit = n_emit + 2'd1;
                  mode_in = MODE_IDLE;
               end
            end
            MODE_ZERO, MODE_INT: begin
               if (mode_ff == MODE_ZERO && (b == "x" || b == "X")) begin
                  mode_in = MODE_HEX;
               end else if (is_digit(b)) begin
                  mode_in = MODE_INT;
               end else if (b == ".") begin
                  mode_in = MODE_DOT;
                  dot_in = pos_ff;
               end else if (b == "e" || b == "E") begin
                  mode_in = MODE_EXP_START;
               end else if (is_suffix(b)) begin
                  mode_in = MODE_SUFFIX;
               end else begin
                  em[n_emit] = mk_emit(KIND_NUMBER, begin_ff, pos_ff - begin_ff, 1'b0, 1'b0);
                  n_emit = n_emit + 2'd1;
                  do_start = 1'b1;
               end
            end
            MODE_DOT: begin
               if (is_digit(b)) begin
                  mode_in = MODE_FRAC;
               end else begin
                  em[n_emit] = mk_emit(KIND_NUMBER, begin_ff, dot_ff - begin_ff, 1'b0, 1'b0);
                  n_emit = n_emit + 2'd1;
                  em[n_emit] = mk_emit(KIND_OTHER, dot_ff, PB'(1), 1'b0, 1'b0);
                  n_emit = n_emit + 2'd1;
                  do_start = 1'b1;
               end
            end
            MODE_FRAC, MODE_EXP_START, MODE_EXP, MODE_SUFFIX: begin
               if (mode_ff == MODE_FRAC && is_digit(b)) begin
                  mode_in = MODE_FRAC;
               end else if (mode_ff == MODE_FRAC && (b == "e" || b == "E")) begin
                  mode_in = MODE_EXP_START;
               end else if (mode_ff == MODE_EXP_START && (b == "+" || b == "-" || is_digit(b)))
               begin
                  mode_in = MODE_EXP;
               end else if (mode_ff == MODE_EXP && is_digit(b)) begin
                  mode_in = MODE_EXP;
               end else if (is_suffix(b)) begin
                  mode_in = MODE_SUFFIX;
               end else begin
                  em[n_emit] = mk_emit(KIND_NUMBER, begin_ff, pos_ff - begin_ff, 1'b0, 1'b0);
                  n_emit = n_emit + 2'd1;
                  do_start = 1'b1;
               end
            end
            MODE_HEX: begin
               if (!is_hex(b)) begin
                  em[n_emit] = mk_emit(KIND_NUMBER, begin_ff, pos_ff - begin_ff, 1'b0, 1'b0);
                  n_emit = n_emit + 2'd1;
                  do_start = 1'b1;
               end
            end
            MODE_SLASH: begin
               if (b == "/") begin
                  mode_in = MODE_LINE;
               end else if (b == "*") begin
                  mode_in = MODE_BLOCK;
               end else begin
                  em[n_emit] = mk_emit(KIND_OTHER, begin_ff, PB'(1), 1'b0, 1'b0);
                  n_emit = n_emit + 2'd1;
                  do_start = 1'b1;
               end
            end
            MODE_LINE: begin
               if (b == 8'h0A) begin
                  do_start = 1'b1;
               end
            end
            MODE_BLOCK: begin
               if (b == "*") begin
                  mode_in = MODE_BLOCK_STAR;
               end
            end
            MODE_BLOCK_STAR: begin
               if (b == "/") begin
                  mode_in = MODE_IDLE;
               end else if (b != "*") begin
                  mode_in = MODE_BLOCK;
               end
            end
            default: begin
               do_start = 1'b1;
            end
         endcase

         if (do_start) begin
            mode_in = MODE_IDLE;
            if (is_alpha(b)) begin
               mode_in = MODE_IDENT;
               begin_in = pos_ff;
               prog_in = 3'd1;
               cand_in = (b == "r");
            end else if (b == "\"" || b == "'") begin
               mode_in = (b == "\"") ? MODE_STR_D : MODE_STR_S;
               begin_in = sat_inc(pos_ff);
            end else if (is_digit(b)) begin
               mode_in = (b == "0") ? MODE_ZERO : MODE_INT;
               begin_in = pos_ff;
            end else if (b == "/") begin
               mode_in = MODE_SLASH;
               begin_in = pos_ff;
            end else begin
               em[n_emit] = mk_emit(KIND_OTHER, pos_ff, PB'(1), 1'b0, (b == "(" || b == " "));
               n_emit = n_emit + 2'd1;
            end
         end

         prev2_in = prev_ff;
         prev_in = b;
         pos_in = sat_inc(pos_ff);
      end
   end

   always_comb begin
      logic ar;
      ar = ar_ff;
      push_group = '0;
      push_group.count = n_emit;
      for (int i = 0; i < GROUP_SIZE; i++) begin
         if (2'(i) < n_emit) begin
            push_group.tok[i].kind = em[i].kind;
            push_group.tok[i].start = clamp16(em[i].start);
            push_group.tok[i].length = clamp16(em[i].length);
            push_group.tok[i].follows = (em[i].kind == KIND_STRING) ? ar : 1'b0;
            if (em[i].kind != KIND_STRING && !em[i].trans) begin
               ar = em[i].req;
            end
         end
      end
      ar_in = req_end_of_text ? 1'b0 : ar;
      push_valid = accept && (n_emit != 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         pos_ff <= '0;
         begin_ff <= '0;
         dot_ff <= '0;
         prev_ff <= '0;
         prev2_ff <= '0;
         prog_ff <= '0;
         cand_ff <= 1'b1;
         ar_ff <= 1'b0;
      end else if (accept) begin
         mode_ff <= mode_in;
         pos_ff <= pos_in;
         begin_ff <= begin_in;
         dot_ff <= dot_in;
         prev_ff <= prev_in;
         prev2_ff <= prev2_in;
         prog_ff <= prog_in;
         cand_ff <= cand_in;
         ar_ff <= ar_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/sts_queue.sv
// Token group queue between the lexer front end and the output back end.
`timescale 1ns / 1ps
`default_nettype none

module sts_queue import sts_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push_valid,
   input  wire group_type push_group,
   input  wire logic      pop,
   output queue_status_type q_status,
   output group_type      head
);

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

   group_type             entries_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0]     count_ff, count_in;

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;
      count_in = count_ff + (PTR_BITS + 1)'(push_valid) - (PTR_BITS + 1)'(pop);
      q_status.full = (count_ff == (PTR_BITS + 1)'(QUEUE_DEPTH));
      q_status.empty = (count_ff == '0);
   end

   assign head = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_group;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/sts_back.sv
// Back end: walks the head token group and drives the registered result port.
`timescale 1ns / 1ps
`default_nettype none

module sts_back import sts_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire queue_status_type q_status,
   input  wire group_type        head,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [1:0]            rsp_token_kind,
   output logic [15:0]           rsp_token_start,
   output logic [15:0]           rsp_token_length,
   output logic                  rsp_follows_require,
   output logic                  rsp_last
);

   logic       valid_ff, valid_in;
   logic [1:0] sub_ff, sub_in;
   token_type  tok_ff;
   logic       last_ff;
   logic       load;
   logic       is_last;

   always_comb begin
      load = !q_status.empty && (!valid_ff || rsp_ready);
      is_last = (sub_ff == head.count - 2'd1);
      pop = load && is_last;
      if (load) begin
         valid_in = 1'b1;
         sub_in = is_last ? 2'd0 : sub_ff + 2'd1;
      end else begin
         valid_in = valid_ff && !rsp_ready;
         sub_in = sub_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         tok_ff <= head.tok[sub_ff];
         last_ff <= is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sub_ff <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         sub_ff <= sub_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_token_kind = tok_ff.kind;
   assign rsp_token_start = tok_ff.start;
   assign rsp_token_length = tok_ff.length;
   assign rsp_follows_require = tok_ff.follows;
   assign rsp_last = last_ff;

endmodule

`default_nettype wire

>>> rtl/script_token_scanner_top.sv
// Top level of the script token scanner: lexer front end, group queue, output back end.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_char_code, req_end_of_text
//   rsp      out        rsp_valid / rsp_ready  rsp_token_kind, start, length, follows, last
//
// One byte word is taken in every cycle while the four-entry group queue has room.
// Token words leave the output register one per cycle while rsp_ready is high, so a byte
// that closes three tokens holds the result port for three token words.
// A token reaches the result port from its byte through the queue write, then the output register load.
// Reset is synchronous and empties the queue and the output register.
// A stalled result port fills the queue, which then drops req_ready.
`timescale 1ns / 1ps
`default_nettype none

`include "script_token_scanner_top_macros.svh"

module script_token_scanner_top import sts_pkg::*; #(
   parameter int POSITION_BITS = STS_POSITION_BITS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_char_code,
   input  wire logic        req_end_of_text,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_token_kind,
   output logic [15:0]      rsp_token_start,
   output logic [15:0]      rsp_token_length,
   output logic             rsp_follows_require,
   output logic             rsp_last
);

   queue_status_type q_status;
   logic             push_valid;
   group_type        push_group;
   group_type        head;
   logic             pop;

   sts_front #(
      .POSITION_BITS(POSITION_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_char_code   (req_char_code),
      .req_end_of_text (req_end_of_text),
      .q_status        (q_status),
      .push_valid      (push_valid),
      .push_group      (push_group)
   );

   sts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_group (push_group),
      .pop        (pop),
      .q_status   (q_status),
      .head       (head)
   );

   sts_back u_back (
      .clock               (clock),
      .reset               (reset),
      .q_status            (q_status),
      .head                (head),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_token_kind      (rsp_token_kind),
      .rsp_token_start     (rsp_token_start),
      .rsp_token_length    (rsp_token_length),
      .rsp_follows_require (rsp_follows_require),
      .rsp_last            (rsp_last)
   );

   `STS_ASSERT_NEXT(a_queue_feeds_output, clock, reset, !q_status.empty, rsp_valid, "Queued tokens did not reach the result port.")
   `STS_ASSERT_NEXT(a_group_unbroken, clock, reset, rsp_valid && rsp_ready && !rsp_last, rsp_valid, "A token group was split by an idle cycle.")
   `STS_ASSERT_SAME(a_follows_only_string, clock, reset, rsp_valid && (rsp_token_kind != KIND_STRING), !rsp_follows_require, "Require flag set on a token that is not a string.")

endmodule

`default_nettype wire
